// ===== sv/msh_pkg.sv =====
package msh_pkg;

  localparam int VALUE_W       = 16;
  localparam int HASH_W        = 32;
  localparam int SIG_W         = 16;
  localparam int NUM_BITS      = 16;
  localparam int MAX_GROUP_LEN = 4096;

  localparam logic [HASH_W-1:0] MM_C1     = 32'hcc9e2d51;
  localparam logic [HASH_W-1:0] MM_C2     = 32'h1b873593;
  localparam logic [HASH_W-1:0] MM_ADD    = 32'he6546b64;
  localparam logic [HASH_W-1:0] MM_F1     = 32'h85ebca6b;
  localparam logic [HASH_W-1:0] MM_F2     = 32'hc2b2ae35;
  localparam logic [HASH_W-1:0] MM_H_MUL  = 32'd5;
  localparam logic [HASH_W-1:0] MM_KEYLEN = 32'd8;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_K1,
    OP_K2,
    OP_H5,
    OP_F1,
    OP_F2,
    OP_VOTE
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_full;
  } status_t;

endpackage

// ===== sv/msh_in_if.sv =====
interface msh_in_if;
  logic                        valid;
  logic                        ready;
  logic [msh_pkg::VALUE_W-1:0] sketch_value;
  logic                        last_in_group;

  modport source (output valid, output sketch_value, output last_in_group, input ready);
  modport sink   (input valid, input sketch_value, input last_in_group, output ready);
endinterface

// ===== sv/msh_out_if.sv =====
interface msh_out_if;
  logic                      valid;
  logic                      ready;
  logic [msh_pkg::SIG_W-1:0] signature;

  modport source (output valid, output signature, input ready);
  modport sink   (input valid, input signature, output ready);
endinterface

// ===== sv/msh_cfg_if.sv =====
interface msh_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [msh_pkg::HASH_W-1:0] hash_seed;

  modport source (output valid, output hash_seed, input ready);
  modport sink   (input valid, input hash_seed, output ready);
endinterface

// ===== sv/murmur_simhash_group_signature.sv =====
// Each accepted item passes the load step, five multiply steps on one shared
// 32x32 multiplier and the vote update; the vote of a group's last item raises out valid.
// A new item is accepted only once the current one has finished its vote step.
// A final vote waits while an earlier result is still pending on out.
// Reset (rst_n low, synchronous): seed 0, vote counters zero, no result held.
module murmur_simhash_group_signature #(
  parameter int MAX_GROUP_LEN = msh_pkg::MAX_GROUP_LEN
) (
  input logic        clk,
  input logic        rst_n,
  msh_in_if.sink     in_item,
  msh_out_if.source  out_item,
  msh_cfg_if.sink    cfg_wr
);

  msh_pkg::cmd_t    cmd;
  msh_pkg::status_t status;

  assign cfg_wr.ready = 1'b1;

  msh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  msh_dp #(
    .MAX_GROUP_LEN (MAX_GROUP_LEN)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_value      (in_item.sketch_value),
    .in_last       (in_item.last_in_group),
    .cfg_valid     (cfg_wr.valid),
    .cfg_seed      (cfg_wr.hash_seed),
    .out_ready     (out_item.ready),
    .out_valid     (out_item.valid),
    .out_signature (out_item.signature)
  );

endmodule

// ===== sv/msh_ctrl.sv =====
module msh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  msh_pkg::status_t status,
  output msh_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_H5,
    S_F1,
    S_F2,
    S_VOTE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = msh_pkg::OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = msh_pkg::OP_LOAD;
        if (in_valid) begin
          state_nxt = S_K1;
        end
      end
      S_K1: begin
        cmd.op    = msh_pkg::OP_K1;
        state_nxt = S_K2;
      end
      S_K2: begin
        cmd.op    = msh_pkg::OP_K2;
        state_nxt = S_H5;
      end
      S_H5: begin
        cmd.op    = msh_pkg::OP_H5;
        state_nxt = S_F1;
      end
      S_F1: begin
        cmd.op    = msh_pkg::OP_F1;
        state_nxt = S_F2;
      end
      S_F2: begin
        cmd.op    = msh_pkg::OP_F2;
        state_nxt = S_VOTE;
      end
      S_VOTE: begin
        // hold the final vote until the result register is free
        if (!(status.last && status.out_full)) begin
          cmd.op    = msh_pkg::OP_VOTE;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_starts_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (cmd.op == msh_pkg::OP_K1))
    else $error("accepted item did not start hashing");

  a_f2_then_vote_state: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == msh_pkg::OP_F2) |=> (state_r == S_VOTE))
    else $error("hash sequence skipped the vote step");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == msh_pkg::OP_K1 || cmd.op == msh_pkg::OP_F2) |-> !in_ready)
    else $error("item taken while hashing");

endmodule

// ===== sv/msh_dp.sv =====
module msh_dp #(
  parameter int MAX_GROUP_LEN = msh_pkg::MAX_GROUP_LEN
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  msh_pkg::cmd_t               cmd,
  output msh_pkg::status_t            status,
  input  logic [msh_pkg::VALUE_W-1:0] in_value,
  input  logic                        in_last,
  input  logic                        cfg_valid,
  input  logic [msh_pkg::HASH_W-1:0]  cfg_seed,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [msh_pkg::SIG_W-1:0]   out_signature
);

  localparam int CW = $clog2(MAX_GROUP_LEN + 1) + 1;
  localparam logic signed [CW-1:0] CNT_MAX = CW'(MAX_GROUP_LEN);
  localparam logic signed [CW-1:0] CNT_MIN = -CNT_MAX;

  logic [msh_pkg::HASH_W-1:0] seed_r;
  logic [msh_pkg::HASH_W-1:0] acc_r;
  logic [msh_pkg::HASH_W-1:0] acc_nxt;
  logic                       last_r;
  logic [msh_pkg::HASH_W-1:0] mul_b;
  logic [msh_pkg::HASH_W-1:0] prod;
  logic [msh_pkg::HASH_W-1:0] tmp;
  logic [msh_pkg::SIG_W-1:0]  folded;
  logic [msh_pkg::SIG_W-1:0]  sig_nxt;
  logic signed [CW-1:0]       cnt_r   [msh_pkg::NUM_BITS];
  logic signed [CW-1:0]       cnt_upd [msh_pkg::NUM_BITS];
  logic                       out_valid_r;
  logic [msh_pkg::SIG_W-1:0]  out_sig_r;
  logic                       cnt_in_range;
  logic                       cnt_all_zero;
  logic                       vote_last;

  assign status.last     = last_r;
  assign status.out_full = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_signature   = out_sig_r;
  assign vote_last       = (cmd.op == msh_pkg::OP_VOTE) && last_r;

  always_comb begin
    case (cmd.op)
      msh_pkg::OP_K1: mul_b = msh_pkg::MM_C1;
      msh_pkg::OP_K2: mul_b = msh_pkg::MM_C2;
      msh_pkg::OP_H5: mul_b = msh_pkg::MM_H_MUL;
      msh_pkg::OP_F1: mul_b = msh_pkg::MM_F1;
      msh_pkg::OP_F2: mul_b = msh_pkg::MM_F2;
      default:        mul_b = '0;
    endcase
  end

  assign prod = acc_r * mul_b;

  always_comb begin
    acc_nxt = acc_r;
    tmp     = '0;
    case (cmd.op)
      msh_pkg::OP_LOAD: acc_nxt = {{(msh_pkg::HASH_W - msh_pkg::VALUE_W){1'b0}}, in_value};
      msh_pkg::OP_K1:   acc_nxt = {prod[16:0], prod[31:17]};
      msh_pkg::OP_K2: begin
        tmp     = seed_r ^ prod;
        acc_nxt = {tmp[18:0], tmp[31:19]};
      end
      msh_pkg::OP_H5: begin
        tmp     = (prod + msh_pkg::MM_ADD) ^ msh_pkg::MM_KEYLEN;
        acc_nxt = tmp ^ (tmp >> 16);
      end
      msh_pkg::OP_F1:   acc_nxt = prod ^ (prod >> 13);
      msh_pkg::OP_F2:   acc_nxt = prod ^ (prod >> 16);
      default:          acc_nxt = acc_r;
    endcase
  end

  assign folded = acc_r[15:0] ^ acc_r[31:16];

  always_comb begin
    cnt_in_range = 1'b1;
    cnt_all_zero = 1'b1;
    for (int j = 0; j < msh_pkg::NUM_BITS; j++) begin
      cnt_upd[j] = cnt_r[j];
      if (folded[j]) begin
        if (cnt_r[j] < CNT_MAX) cnt_upd[j] = cnt_r[j] + CW'(1);
      end else begin
        if (cnt_r[j] > CNT_MIN) cnt_upd[j] = cnt_r[j] - CW'(1);
      end
      sig_nxt[j] = (cnt_upd[j] > $signed(CW'(0)));
      if (cnt_r[j] > CNT_MAX || cnt_r[j] < CNT_MIN) cnt_in_range = 1'b0;
      if (cnt_r[j] != '0) cnt_all_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < msh_pkg::NUM_BITS; j++) cnt_r[j] <= '0;
    end else begin
      if (cfg_valid) seed_r <= cfg_seed;
      if (vote_last) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.op == msh_pkg::OP_VOTE) begin
        for (int j = 0; j < msh_pkg::NUM_BITS; j++) begin
          cnt_r[j] <= last_r ? '0 : cnt_upd[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.op == msh_pkg::OP_LOAD) last_r <= in_last;
    if (vote_last) out_sig_r <= sig_nxt;
  end

  a_out_from_vote: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(vote_last))
    else $error("result raised without a final vote");

  a_clear_after_group: assert property (@(posedge clk) disable iff (!rst_n)
    vote_last |=> cnt_all_zero)
    else $error("vote counters not cleared after group");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_in_range)
    else $error("vote counter out of saturation range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    vote_last |-> !(out_valid_r && !out_ready))
    else $error("pending result overwritten");

endmodule
